### hw/rtl/tcc_pkg.sv
// tcc_pkg: shared types, constants and helpers of the text console.
// Used by every console module except tcc_ram; depends on nothing else.
package tcc_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STOP   = 8;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = 11;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int CELL_W     = 16;

   // input modes
   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // control characters and the printable range
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_PRINT_MAX = 8'h7F;
   localparam logic [7:0] ATTR_RESET     = 8'h0F;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP,
      OP_BS,
      OP_TAB,
      OP_CR,
      OP_LF,
      OP_PUT,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [ADDR_W-1:0] cursor_location;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] cell_index;
   } cmd_type;

   // linear cell address of a row and column
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

### hw/rtl/tcc_ram.sv
// tcc_ram: generic single write, single read RAM with registered read data.
// Standalone; holds the screen cells of the console.
module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] cells_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tcc_front.sv
// tcc_front: decodes an incoming request into one console operation.
// Depends on tcc_pkg.
module tcc_front (
   input  tcc_pkg::req_type req_data,
   output tcc_pkg::cmd_type cmd
);
   import tcc_pkg::*;

   op_type op;

   // classify mode and character
   always_comb begin
      op = OP_NOP;
      case (req_data.mode)
         MODE_PUT: begin
            if (req_data.char_code == CHAR_BS) begin
               op = OP_BS;
            end else if (req_data.char_code == CHAR_TAB) begin
               op = OP_TAB;
            end else if (req_data.char_code == CHAR_CR) begin
               op = OP_CR;
            end else if (req_data.char_code == CHAR_LF) begin
               op = OP_LF;
            end else if (req_data.char_code >= CHAR_SPACE &&
                         req_data.char_code <= CHAR_PRINT_MAX) begin
               op = OP_PUT;
            end
         end
         MODE_CLEAR: begin
            op = OP_CLEAR;
         end
         MODE_READ: begin
            // a read past the screen reports zero data, same as a no-op
            if (req_data.cell_index < ADDR_W'(CELL_COUNT)) begin
               op = OP_READ;
            end
         end
         default: begin
            op = OP_NOP;
         end
      endcase
   end

   assign cmd.op         = op;
   assign cmd.char_code  = req_data.char_code;
   assign cmd.cell_index = req_data.cell_index;

endmodule

### hw/rtl/tcc_queue.sv
// tcc_queue: two-entry queue of decoded operations between front and back.
// Depends on tcc_pkg.
module tcc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output tcc_pkg::cmd_type pop_cmd
);
   import tcc_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/tcc_back.sv
// tcc_back: executes console operations on the cursor and the screen store.
// Depends on tcc_pkg and tcc_ram; owns the attribute register and result register.
module tcc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  tcc_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcc_pkg::rsp_type rsp_data
);
   import tcc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SCROLL,
      ST_DRAIN,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic              scrolled_ff, scrolled_in;
   logic [7:0]        attr_ff, attr_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_free;
   logic [COL_W:0]    ncol;
   logic [ROW_W:0]    nrow;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // cursor motion of a put operation, with column wrap but before scroll
   always_comb begin
      ncol = {1'b0, col_ff};
      nrow = {1'b0, row_ff};
      case (cmd_ff.op)
         OP_BS: begin
            if (col_ff != '0) begin
               ncol = {1'b0, col_ff} - 1'b1;
            end
         end
         OP_TAB: begin
            // tab stop is a power of two, so the remainder is a mask
            ncol = {1'b0, col_ff} - (COL_W + 1)'(col_ff % COL_W'(TAB_STOP))
                   + (COL_W + 1)'(TAB_STOP);
         end
         OP_CR: begin
            ncol = '0;
         end
         OP_LF: begin
            ncol = '0;
            nrow = {1'b0, row_ff} + 1'b1;
         end
         OP_PUT: begin
            ncol = {1'b0, col_ff} + 1'b1;
         end
         default: begin
            ncol = {1'b0, col_ff};
         end
      endcase
      // column wrap
      if (ncol >= (COL_W + 1)'(COLUMNS)) begin
         ncol = '0;
         nrow = nrow + 1'b1;
      end
   end

   // screen store port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cell_addr(row_ff, col_ff);
      ram_wr_data = {attr_ff, cmd_ff.char_code};
      if (pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pend_addr_ff;
         ram_wr_data = ram_rd_data;
      end else if (state_ff == ST_FILL) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = ptr_ff;
         ram_wr_data = {attr_ff, CHAR_SPACE};
      end else if (state_ff == ST_EXEC && cmd_ff.op == OP_PUT) begin
         ram_wr_en   = 1'b1;
      end
      ram_rd_addr = (state_ff == ST_SCROLL) ? ptr_ff : cmd_ff.cell_index;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      pend_in      = (state_ff == ST_SCROLL);
      pend_addr_in = ptr_ff - ADDR_W'(COLUMNS);
      data_in      = data_ff;
      scrolled_in  = scrolled_ff;
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            data_in     = '0;
            scrolled_in = 1'b0;
            state_in    = ST_DONE;
            case (cmd_ff.op)
               OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  ptr_in   = '0;
                  state_in = ST_FILL;
               end
               OP_READ: begin
                  state_in = ST_READ_WAIT;
               end
               OP_NOP: begin
                  state_in = ST_DONE;
               end
               default: begin
                  col_in = ncol[COL_W-1:0];
                  row_in = nrow[ROW_W-1:0];
                  // row past the bottom: scroll up one line
                  if (nrow >= (ROW_W + 1)'(ROWS)) begin
                     row_in      = ROW_W'(ROWS - 1);
                     scrolled_in = 1'b1;
                     ptr_in      = ADDR_W'(COLUMNS);
                     state_in    = ST_SCROLL;
                  end
               end
            endcase
         end
         ST_READ_WAIT: begin
            data_in  = ram_rd_data;
            state_in = ST_DONE;
         end
         ST_SCROLL: begin
            // read a cell one line down, write it back one line up next cycle
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ptr_in   = ADDR_W'(CELL_COUNT - COLUMNS);
            state_in = ST_FILL;
         end
         ST_FILL: begin
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_in.cursor_row      = row_ff;
               out_in.cursor_col      = col_ff;
               out_in.cursor_location = cell_addr(row_ff, col_ff);
               out_in.cell_data       = data_ff;
               out_in.scrolled        = scrolled_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, cursor and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         attr_ff      <= ATTR_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         attr_ff      <= attr_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff       <= cmd_in;
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      data_ff      <= data_in;
      scrolled_ff  <= scrolled_in;
      out_ff       <= out_in;
   end

   // screen store
   tcc_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_screen (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

### hw/rtl/text_console_cursor_scroll.sv
// text_console_cursor_scroll: top level of the 80x25 character-cell console.
// Depends on tcc_pkg, tcc_front, tcc_queue, tcc_back and tcc_ram.
//
// Usage:
//   Request channel (req_valid / req_stall / req_data): mode 0 puts a byte
//   at the cursor or applies a control code, mode 1 clears the screen and
//   homes the cursor, mode 2 reads one cell. Each request gives exactly one
//   response on rsp_valid / rsp_stall / rsp_data with the cursor, its linear
//   location, the cell read (zero otherwise) and a scroll flag.
//   csr_wr_en / csr_wr_data write the attribute byte used for written
//   characters and blanks; write it only while no request is in flight.
// Timing:
//   Requests are decoded on entry and held in a two-entry queue, so up to two
//   are taken while the sequencer is busy. A read waits on the registered
//   RAM read in ST_READ_WAIT. A put, tab or line feed that scrolls adds one
//   pass over the store: 1920 cells moved up one line, a drain step, then 80
//   blanks written. A clear writes every cell once.
//   Reset homes the cursor, sets the attribute to 0x0F and empties the queue;
//   the screen holds nothing defined until cleared or written.
//   While rsp_stall is high one finished response waits in the output
//   register and the sequencer holds the next one; the queue keeps filling.
module text_console_cursor_scroll (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import tcc_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   logic    queue_pop;

   assign req_stall = queue_full;

   // request decode
   tcc_front u_front (
      .req_data(req_data),
      .cmd     (front_cmd)
   );

   // operation queue
   tcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid && !queue_full),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .not_empty(queue_not_empty),
      .pop_cmd  (queue_cmd)
   );

   // execution and screen store
   tcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (queue_not_empty),
      .q_cmd      (queue_cmd),
      .q_pop      (queue_pop),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### tb/text_console_cursor_scroll_tb.sv
// text_console_cursor_scroll_tb: self-checking bench for the character-cell console.
// Predicts the cursor, scroll flag and cell reads in-house; depends on tcc_pkg and
// text_console_cursor_scroll.
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb;
   import tcc_pkg::*;

   // mode value the block leaves unused
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int INDEX_MAX      = (1 << ADDR_W) - 1;
   localparam int QUIET_LIMIT    = 20000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [7:0]       csr_wr_data;

   // shadow copy of the console
   logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
   int                shadow_row;
   int                shadow_col;
   logic [7:0]        shadow_attr;
   bit                screen_known;

   rsp_type pending_cursor_reports[$];
   int      error_count;
   bit      idle_enabled;
   int      long_hold_cycles;

   text_console_cursor_scroll dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // apply one request to the shadow console and return the cursor report
   function automatic rsp_type advance_console(input req_type item);
      rsp_type          report;
      logic [CELL_W-1:0] blank;
      int               i;
      report = '0;
      blank  = {shadow_attr, CHAR_SPACE};
      case (item.mode)
         MODE_PUT: begin
            if (item.char_code == CHAR_BS) begin
               if (shadow_col != 0) shadow_col--;
            end else if (item.char_code == CHAR_TAB) begin
               shadow_col = shadow_col + TAB_STOP - ((shadow_col + TAB_STOP) % TAB_STOP);
            end else if (item.char_code == CHAR_CR) begin
               shadow_col = 0;
            end else if (item.char_code == CHAR_LF) begin
               shadow_col = 0;
               shadow_row++;
            end else if (item.char_code >= CHAR_SPACE && item.char_code <= CHAR_PRINT_MAX) begin
               shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, item.char_code};
               shadow_col++;
            end
            // wrap past the last column
            if (shadow_col >= COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            // scroll up one line past the last row
            if (shadow_row >= ROWS) begin
               for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                  shadow_screen[i] = shadow_screen[i + COLUMNS];
               for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  shadow_screen[i] = blank;
               shadow_row = ROWS - 1;
               report.scrolled = 1'b1;
            end
         end
         MODE_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++) shadow_screen[i] = blank;
            shadow_row   = 0;
            shadow_col   = 0;
            screen_known = 1'b1;
         end
         MODE_READ: begin
            if (item.cell_index < CELL_COUNT) report.cell_data = shadow_screen[item.cell_index];
         end
         default: ;
      endcase
      report.cursor_row      = ROW_W'(shadow_row);
      report.cursor_col      = COL_W'(shadow_col);
      report.cursor_location = ADDR_W'(shadow_row * COLUMNS + shadow_col);
      return report;
   endfunction

   // offer one request, wait for it to be taken and record its report
   task automatic send_request(input logic [1:0] mode, input logic [7:0] code,
                               input logic [ADDR_W-1:0] index);
      req_type item;
      item.mode       = mode;
      item.char_code  = code;
      item.cell_index = index;
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_cursor_reports.push_back(advance_console(item));
   endtask

   // stop offering and wait for every report to come back
   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cursor_reports.size() != 0);
   endtask

   task automatic write_attribute(input logic [7:0] value);
      drain_requests();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_attr = value;
   endtask

   task automatic test_clear_and_home();
      send_request(MODE_CLEAR, 8'h00, '0);
      send_request(MODE_READ, 8'h00, '0);
      send_request(MODE_READ, 8'h00, ADDR_W'(CELL_COUNT - 1));
   endtask

   task automatic test_printable_range();
      send_request(MODE_PUT, CHAR_SPACE, '0);
      send_request(MODE_PUT, CHAR_PRINT_MAX, '0);
      send_request(MODE_PUT, 8'h41, ADDR_W'(INDEX_MAX));
      send_request(MODE_READ, 8'h00, ADDR_W'(0));
      send_request(MODE_READ, 8'hFF, ADDR_W'(1));
   endtask

   task automatic test_control_codes();
      // backspace mid-line, then tabs, then backspace at column zero
      send_request(MODE_PUT, CHAR_BS, '0);
      send_request(MODE_PUT, CHAR_TAB, '0);
      send_request(MODE_PUT, CHAR_TAB, '0);
      send_request(MODE_PUT, CHAR_CR, '0);
      send_request(MODE_PUT, CHAR_BS, '0);
      send_request(MODE_PUT, CHAR_LF, '0);
      // bytes that leave screen and cursor alone
      send_request(MODE_PUT, 8'h00, '0);
      send_request(MODE_PUT, 8'(CHAR_SPACE - 8'd1), '0);
      send_request(MODE_PUT, 8'(CHAR_PRINT_MAX + 8'd1), '0);
      send_request(MODE_PUT, 8'hFF, ADDR_W'(INDEX_MAX));
      send_request(MODE_UNUSED, 8'hFF, ADDR_W'(INDEX_MAX));
   endtask

   task automatic test_read_out_of_range();
      send_request(MODE_READ, 8'h00, ADDR_W'(CELL_COUNT));
      send_request(MODE_READ, 8'h00, ADDR_W'(INDEX_MAX));
   endtask

   // hold the response side off long enough for the input to back up
   task automatic test_output_hold();
      int i;
      idle_enabled     = 1'b0;
      long_hold_cycles = HOLD_CYCLES;
      for (i = 0; i < 6; i++)
         send_request(MODE_PUT, 8'($urandom_range(CHAR_SPACE, CHAR_PRINT_MAX)), '0);
      drain_requests();
      idle_enabled = 1'b1;
   endtask

   // text lines with random content, mixed with controls, reads and noise
   task automatic test_random_text(input int target);
      int         counted;
      int         pick;
      logic [1:0] mode;
      logic [7:0] code;
      logic [ADDR_W-1:0] index;
      counted = 0;
      while (counted < target) begin
         mode    = MODE_PUT;
         code    = 8'($urandom_range(CHAR_SPACE, CHAR_PRINT_MAX));
         index   = ADDR_W'($urandom_range(0, INDEX_MAX));
         pick    = $urandom_range(0, 399);
         if (pick == 0) begin
            mode = MODE_CLEAR;
         end else if (pick < 9) begin
            mode    = MODE_UNUSED;
            code    = 8'($urandom_range(0, 255));
         end else if (pick < 60) begin
            mode = MODE_READ;
            code = 8'($urandom_range(0, 255));
            if (!screen_known || $urandom_range(0, 9) == 0)
               index = ADDR_W'($urandom_range(CELL_COUNT, INDEX_MAX));
            else
               index = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
         end else if (pick < 80) begin
            code = CHAR_LF;
         end else if (pick < 88) begin
            code = CHAR_CR;
         end else if (pick < 100) begin
            code = CHAR_TAB;
         end else if (pick < 112) begin
            code = CHAR_BS;
         end else if (pick < 132) begin
            // control or high byte with no meaning
            do code = 8'($urandom_range(0, 255));
            while (code == CHAR_BS || code == CHAR_TAB || code == CHAR_LF ||
                   code == CHAR_CR || (code >= CHAR_SPACE && code <= CHAR_PRINT_MAX));
         end
         send_request(mode, code, index);
         counted++;
      end
   endtask

   // response stall: random bursts plus the long hold on request
   initial begin : rsp_stall_gen
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            if (long_hold_cycles > 0) begin
               stall_left       = long_hold_cycles;
               long_hold_cycles = 0;
            end else if (idle_enabled && $urandom_range(0, 23) == 0) begin
               stall_left = $urandom_range(1, 19);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_cursor_reports.size() == 0) begin
            $error("response with no request pending");
            error_count++;
         end else begin
            want = pending_cursor_reports.pop_front();
            check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_data.cursor_row));
            check_field("cursor_col", 32'(want.cursor_col), 32'(rsp_data.cursor_col));
            check_field("cursor_location", 32'(want.cursor_location),
                        32'(rsp_data.cursor_location));
            check_field("cell_data", 32'(want.cell_data), 32'(rsp_data.cell_data));
            check_field("scrolled", 32'(want.scrolled), 32'(rsp_data.scrolled));
         end
      end
   end

   // end the run if nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : test_sequence
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      error_count      = 0;
      idle_enabled     = 1'b1;
      long_hold_cycles = 0;
      shadow_row       = 0;
      shadow_col       = 0;
      shadow_attr      = ATTR_RESET;
      screen_known     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_clear_and_home();
      test_printable_range();
      test_control_codes();
      test_read_out_of_range();
      test_output_hold();

      write_attribute(8'h00);
      test_random_text(500);
      write_attribute(8'hFF);
      test_random_text(500);
      write_attribute(8'($urandom_range(1, 254)));
      test_random_text(500);
      // closing stretch runs back to back
      idle_enabled = 1'b0;
      write_attribute(8'($urandom_range(0, 255)));
      test_random_text(450);

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
